>>> sv/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types, token codes and byte classes for the tiny-language tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlt_pkg;

  // Longest letter run that still forms an identifier
  localparam int MAX_IDENT_LENGTH = 255;

  // Result token codes
  typedef enum logic [3:0] {
    TK_NUMCHAR    = 4'd0,
    TK_NUMBER     = 4'd1,
    TK_IDENTCHAR  = 4'd2,
    TK_IDENTIFIER = 4'd3,
    TK_EXIT       = 4'd4,
    TK_BADKW      = 4'd5,
    TK_SEMI       = 4'd6,
    TK_LPAREN     = 4'd7,
    TK_RPAREN     = 4'd8,
    TK_PLUS       = 4'd9,
    TK_MINUS      = 4'd10,
    TK_STAR       = 4'd11,
    TK_SLASH      = 4'd12,
    TK_ASSIGN     = 4'd13,
    TK_EQEQ       = 4'd14,
    TK_BADOP      = 4'd15
  } token_kind_e;

  // Source byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // +
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // -
  localparam logic [7:0] CH_STAR   = 8'h2A;  // *
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // /
  localparam logic [7:0] CH_EQUAL  = 8'h3D;  // =

  // Keyword "exit", one letter per position
  localparam logic [7:0] EXIT_WORD [4] = '{8'h65, 8'h78, 8'h69, 8'h74};
  localparam int         EXIT_LEN      = 4;

  // One result item
  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  ch;
    logic [7:0]  len;
    logic        last;
  } res_t;

  // Results produced by one input item (0, 1 or 2)
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } scan_res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

>>> sv/tlt_in_if.sv
// ----------------------------------------------------------------------------
// tlt_in_if
// Source byte channel: valid/ready with one byte and an end-of-input flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

>>> sv/tlt_out_if.sv
// ----------------------------------------------------------------------------
// tlt_out_if
// Token channel: valid/ready with kind, echoed char, length and run marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlt_out_if
  import tlt_pkg::*;
;
  logic        valid;
  logic        ready;
  token_kind_e token_kind;
  logic [7:0]  lexeme_char;
  logic [7:0]  lexeme_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output lexeme_char,
                  output lexeme_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input lexeme_char,
                  input lexeme_length, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> sv/tiny_language_tokenizer.sv
// ----------------------------------------------------------------------------
// tiny_language_tokenizer
// Byte-serial lexer: numbers, identifiers, the keyword exit and operators.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  takes one source byte per transfer, or an end-of-input mark that
//         closes any pending token and returns the scanner to idle.
//   out_o gives 0, 1 or 2 tokens per input transfer; last_of_run marks the
//         final token caused by that byte.
// Path: a byte is registered at its transfer, scanned from the input
//   register, and its tokens are written into the token queue that feeds out_o.
// Throughput: one byte per cycle while the queue has room. The output
//   queue sends one token per cycle, so bytes that close a token and start
//   another (two tokens) are taken at that one-token-per-cycle pace.
// Stall: when out_o is held off, the four-entry token queue fills; once fewer
//   than two free entries remain, the input register holds its byte and
//   in_i.ready drops while it is full. Ready depends only on registered state.
// Reset: rst_ni clears the scanner to idle and empties the queue; no token
//   is pending and out_o.valid is low.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_language_tokenizer
  import tlt_pkg::*;
#(
  parameter int MaxIdentLength = MAX_IDENT_LENGTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tlt_in_if.sink    in_i,
  tlt_out_if.source out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       room;
  logic       advance;
  logic       accept;
  scan_res_t  scan_res;

  assign advance    = in_valid_q && room;
  assign in_i.ready = !in_valid_q || room;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_i.in_byte;
      in_eoi_q  <= in_i.end_of_input;
    end
  end

  tlt_scan #(
    .MaxIdentLength(MaxIdentLength)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .in_byte_i(in_byte_q),
    .eoi_i    (in_eoi_q),
    .res_o    (scan_res)
  );

  tlt_outbuf u_outbuf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(advance),
    .res_i (scan_res),
    .room_o(room),
    .out_o (out_o)
  );

endmodule

`default_nettype wire

>>> sv/tlt_scan.sv
// ----------------------------------------------------------------------------
// tlt_scan
// Scan state (mode, lexeme count, keyword match) and per-byte token logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_scan
  import tlt_pkg::*;
#(
  parameter int MaxIdentLength = MAX_IDENT_LENGTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       eoi_i,
  output scan_res_t       res_o
);

  localparam int CountCap = ((MaxIdentLength + 1) > 255) ? (MaxIdentLength + 1) : 255;
  localparam int CntW     = $clog2(CountCap + 1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_EQ    = 2'd3;

  logic [1:0]      mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      kwm_q, kwm_d;
  logic            mis_q, mis_d;

  logic            dig, alpha;
  logic [CntW-1:0] cnt_inc;
  logic [7:0]      cnt_sat;
  logic            match_ok;
  logic            f_valid;
  res_t            f_res;
  logic            i_valid;
  res_t            i_res;
  logic [1:0]      i_mode;

  assign dig      = is_digit(in_byte_i);
  assign alpha    = is_alpha(in_byte_i);
  assign cnt_inc  = (cnt_q < CntW'(CountCap)) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_sat  = (cnt_q > CntW'(255)) ? 8'hFF : cnt_q[7:0];
  assign match_ok = (cnt_q < CntW'(EXIT_LEN)) && !mis_q &&
                    (in_byte_i == EXIT_WORD[cnt_q[1:0]]);

  // Token closed by the current mode
  always_comb begin
    f_valid = 1'b1;
    f_res   = '{kind: TK_ASSIGN, ch: 8'h00, len: 8'h00, last: 1'b0};
    case (mode_q)
      MODE_NUM: begin
        f_res.kind = TK_NUMBER;
        f_res.len  = cnt_sat;
      end
      MODE_IDENT: begin
        if (cnt_q > CntW'(MaxIdentLength)) begin
          f_res.kind = TK_BADKW;
        end else if (!mis_q && kwm_q == 3'(EXIT_LEN)) begin
          f_res.kind = TK_EXIT;
        end else begin
          f_res.kind = TK_IDENTIFIER;
          f_res.len  = cnt_sat;
        end
      end
      MODE_EQ: f_res.kind = TK_ASSIGN;
      default: f_valid = 1'b0;
    endcase
  end

  // Byte seen from the idle mode
  always_comb begin
    i_valid = 1'b1;
    i_mode  = MODE_IDLE;
    i_res   = '{kind: TK_BADOP, ch: 8'h00, len: 8'h00, last: 1'b0};
    if (dig) begin
      i_mode     = MODE_NUM;
      i_res.kind = TK_NUMCHAR;
      i_res.ch   = in_byte_i;
    end else if (alpha) begin
      i_mode     = MODE_IDENT;
      i_res.kind = TK_IDENTCHAR;
      i_res.ch   = in_byte_i;
    end else begin
      case (in_byte_i)
        CH_SEMI:   i_res.kind = TK_SEMI;
        CH_LPAREN: i_res.kind = TK_LPAREN;
        CH_RPAREN: i_res.kind = TK_RPAREN;
        CH_PLUS:   i_res.kind = TK_PLUS;
        CH_MINUS:  i_res.kind = TK_MINUS;
        CH_STAR:   i_res.kind = TK_STAR;
        CH_SLASH:  i_res.kind = TK_SLASH;
        CH_NUL:    i_res.kind = TK_BADOP;
        CH_EQUAL: begin
          i_valid = 1'b0;
          i_mode  = MODE_EQ;
        end
        default:   i_valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    kwm_d  = kwm_q;
    mis_d  = mis_q;
    res_o  = '0;
    if (eoi_i) begin
      mode_d   = MODE_IDLE;
      cnt_d    = '0;
      kwm_d    = '0;
      mis_d    = 1'b0;
      res_o.n  = {1'b0, f_valid};
      res_o.r0 = f_res;
    end else if (mode_q == MODE_NUM && dig) begin
      cnt_d    = cnt_inc;
      res_o.n  = 2'd1;
      res_o.r0 = '{kind: TK_NUMCHAR, ch: in_byte_i, len: 8'h00, last: 1'b0};
    end else if (mode_q == MODE_IDENT && alpha) begin
      if (match_ok) begin
        kwm_d = kwm_q + 3'd1;
      end else begin
        mis_d = 1'b1;
      end
      cnt_d    = cnt_inc;
      res_o.n  = 2'd1;
      res_o.r0 = '{kind: TK_IDENTCHAR, ch: in_byte_i, len: 8'h00, last: 1'b0};
    end else if (mode_q == MODE_EQ && in_byte_i == CH_EQUAL) begin
      mode_d   = MODE_IDLE;
      res_o.n  = 2'd1;
      res_o.r0 = '{kind: TK_EQEQ, ch: 8'h00, len: 8'h00, last: 1'b0};
    end else begin
      // close the pending token, then treat the byte as a fresh one
      mode_d = i_mode;
      cnt_d  = (dig || alpha) ? CntW'(1) : '0;
      kwm_d  = (alpha && in_byte_i == EXIT_WORD[0]) ? 3'd1 : 3'd0;
      mis_d  = alpha && (in_byte_i != EXIT_WORD[0]);
      if (f_valid) begin
        res_o.r0 = f_res;
        res_o.r1 = i_res;
        res_o.n  = i_valid ? 2'd2 : 2'd1;
      end else begin
        res_o.r0 = i_res;
        res_o.n  = {1'b0, i_valid};
      end
    end
    res_o.r0.last = (res_o.n == 2'd1);
    res_o.r1.last = (res_o.n == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      kwm_q  <= '0;
      mis_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      kwm_q  <= kwm_d;
      mis_q  <= mis_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Outside a number or letter run nothing is counted
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE || mode_q == MODE_EQ) |-> (cnt_q == '0 && kwm_q == '0 && !mis_q))
    else $error("tlt_scan: count or match left over outside a run");

  // While still a keyword candidate, every letter so far has matched
  a_kw_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDENT && !mis_q) |-> (CntW'(kwm_q) == cnt_q))
    else $error("tlt_scan: keyword match out of step with count");

  // Two results only when a token is closed first
  a_two_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.n == 2'd2) |-> (mode_q != MODE_IDLE && !eoi_i))
    else $error("tlt_scan: two results without a pending token");
`endif

endmodule

`default_nettype wire

>>> sv/tlt_outbuf.sv
// ----------------------------------------------------------------------------
// tlt_outbuf
// Four-entry result queue; takes up to two results a cycle, sends one while out_o is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tlt_outbuf
  import tlt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire scan_res_t  res_i,
  output logic            room_o,
  tlt_out_if.source       out_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  res_t            q_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      push_n;
  logic            pop;
  res_t            head;

  assign push_n = push_i ? res_i.n : 2'd0;
  assign pop    = out_o.valid && out_o.ready;
  // room for a full pair, judged on registered count only
  assign room_o = cnt_q <= CntW'(Depth - 2);

  assign head              = q_q[rd_ptr_q];
  assign out_o.valid         = cnt_q != '0;
  assign out_o.token_kind    = head.kind;
  assign out_o.lexeme_char   = head.ch;
  assign out_o.lexeme_length = head.len;
  assign out_o.last_of_run   = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_q[wr_ptr_q] <= res_i.r0;
    end
    if (push_n == 2'd2) begin
      q_q[wr_ptr_q + PtrW'(1)] <= res_i.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> (cnt_q <= CntW'(Depth - 2)))
    else $error("tlt_outbuf: push without room");

  a_pair_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2 && !pop) |=> (cnt_q == $past(cnt_q) + CntW'(2)))
    else $error("tlt_outbuf: pair push lost an entry");

  // A run never shows its head without its final result queued behind it
  a_run_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_of_run) |-> (cnt_q >= CntW'(2)))
    else $error("tlt_outbuf: partial run in queue");
`endif

endmodule

`default_nettype wire
